// ===== hdl/vurt_pkg.sv =====
// ----------------------------------------------------------------------------
// vurt_pkg
// Shared types and constants of the video unit register and timing block.
// ----------------------------------------------------------------------------
package vurt_pkg;

    localparam int NAME_BYTES_DEF  = 4096;
    localparam int DOTS_PER_LINE   = 341;
    localparam int LINES_PER_FRAME = 262;
    localparam int VISIBLE_LINES   = 240;
    localparam int VBLANK_LINE     = 241;
    localparam int LAST_FETCH_DOT  = 256;
    localparam int ROW_STEP        = 32;
    localparam int QDEPTH          = 4;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [13:0] NAME_START    = 14'h2000;
    localparam logic [13:0] PALETTE_START = 14'h3F00;

    typedef enum logic [1:0] {
        LATCH_EMPTY,
        LATCH_HIGH,
        LATCH_FULL
    } latch_t;

    typedef struct packed {
        logic        we;
        logic        re;
        logic [13:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic       valid;
        logic       fetch;
        logic [7:0] rd;
        logic       vblank;
    } issue_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       vblank;
        logic [7:0] tile;
        logic [7:0] attr;
    } result_t;

endpackage

// ===== hdl/vurt_vmem.sv =====
// ----------------------------------------------------------------------------
// vurt_vmem
// Name table memory: single port, registered read.
// ----------------------------------------------------------------------------
module vurt_vmem #(
    parameter int NAME_BYTES = vurt_pkg::NAME_BYTES_DEF
) (
    input  logic               aclk,
    input  vurt_pkg::mem_req_t mreq,
    output logic [7:0]         rdata
);
    import vurt_pkg::*;

    localparam int NAME_AW = $clog2(NAME_BYTES);

    logic [7:0]         name_mem [NAME_BYTES];
    logic [7:0]         rdata_reg;
    logic [12:0]        off_full;
    logic [12:0]        off_wrap;
    logic [NAME_AW-1:0] name_idx;
    logic               is_name;

    // Pattern and palette writes have no read path; only name writes land.
    always_comb begin
        off_full = {1'b0, mreq.addr[11:0]};
        off_wrap = (off_full >= 13'(NAME_BYTES)) ? off_full - 13'(NAME_BYTES) : off_full;
        name_idx = off_wrap[NAME_AW-1:0];
        is_name  = (mreq.addr >= NAME_START) && (mreq.addr < PALETTE_START);
    end

    always_ff @(posedge aclk) begin
        if (mreq.we && is_name) begin
            name_mem[name_idx] <= mreq.wdata;
        end
        if (mreq.re) begin
            rdata_reg <= name_mem[name_idx];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/vurt_ctrl.sv =====
// ----------------------------------------------------------------------------
// vurt_ctrl
// Register file, address latch, dot timing and name memory access issue.
// ----------------------------------------------------------------------------
module vurt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [2:0]         s_reg_index,
    input  logic [7:0]         s_write_data,
    input  logic               room,
    output vurt_pkg::issue_t   issue,
    output vurt_pkg::mem_req_t mreq
);
    import vurt_pkg::*;

    logic [7:0]  regfile_reg [8];
    logic        vblank_reg, vblank_next;
    latch_t      latch_reg, latch_next;
    logic [7:0]  addr_high_reg, addr_high_next;
    logic [15:0] vram_reg, vram_next;
    logic        step_row_reg, step_row_next;
    logic [1:0]  nt_sel_reg, nt_sel_next;
    logic [8:0]  dot_reg, dot_next;
    logic [8:0]  line_reg, line_next;
    logic        attr_pend_reg;
    logic [13:0] attr_addr_reg, attr_addr_next;

    logic        accept;
    logic        is_read;
    logic        is_write;
    logic        is_tick;
    logic        fetch_now;
    logic        data_store;
    logic [4:0]  col;
    logic [4:0]  row;

    assign s_ready = !attr_pend_reg && room;
    assign accept  = s_valid && s_ready;

    always_comb begin
        is_read    = accept && (s_req_type == REQ_READ);
        is_write   = accept && (s_req_type == REQ_WRITE);
        is_tick    = accept && (s_req_type == REQ_TICK);
        col        = 5'(dot_reg[8:3] - 6'd1);
        row        = line_reg[7:3];
        fetch_now  = is_tick && (line_reg < 9'(VISIBLE_LINES)) && (dot_reg != 9'd0)
                     && (dot_reg <= 9'(LAST_FETCH_DOT)) && (dot_reg[2:0] == 3'd0);
        data_store = is_write && (s_reg_index == REG_DATA) && (latch_reg == LATCH_FULL);

        vblank_next    = vblank_reg;
        latch_next     = latch_reg;
        addr_high_next = addr_high_reg;
        vram_next      = vram_reg;
        step_row_next  = step_row_reg;
        nt_sel_next    = nt_sel_reg;
        dot_next       = dot_reg;
        line_next      = line_reg;
        attr_addr_next = {2'b10, nt_sel_reg, 4'b1111, row[4:2], col[4:2]};

        if (is_read && (s_reg_index == REG_STATUS)) begin
            vblank_next = 1'b0;
            latch_next  = LATCH_EMPTY;
        end
        if (is_write) begin
            case (s_reg_index)
                REG_CTRL: begin
                    nt_sel_next   = s_write_data[1:0];
                    step_row_next = s_write_data[2];
                end
                REG_ADDR: begin
                    if (latch_reg != LATCH_HIGH) begin
                        addr_high_next = s_write_data;
                        latch_next     = LATCH_HIGH;
                    end else begin
                        vram_next  = {addr_high_reg, s_write_data};
                        latch_next = LATCH_FULL;
                    end
                end
                default: begin
                end
            endcase
        end
        if (data_store) begin
            vram_next = vram_reg + (step_row_reg ? 16'(ROW_STEP) : 16'd1);
        end
        if (is_tick) begin
            if ((line_reg == 9'(VBLANK_LINE)) && (dot_reg == 9'd1)) begin
                vblank_next = 1'b1;
            end
            if (dot_reg == 9'(DOTS_PER_LINE - 1)) begin
                dot_next  = 9'd0;
                line_next = (line_reg == 9'(LINES_PER_FRAME - 1)) ? 9'd0 : line_reg + 9'd1;
            end else begin
                dot_next = dot_reg + 9'd1;
            end
        end

        mreq       = '0;
        mreq.wdata = s_write_data;
        if (attr_pend_reg) begin
            mreq.re   = 1'b1;
            mreq.addr = attr_addr_reg;
        end else if (fetch_now) begin
            mreq.re   = 1'b1;
            mreq.addr = {2'b10, nt_sel_reg, row, col};
        end else if (data_store) begin
            mreq.we   = 1'b1;
            mreq.addr = vram_reg[13:0];
        end

        issue.valid  = accept;
        issue.fetch  = fetch_now;
        issue.rd     = is_read ? regfile_reg[s_reg_index] : 8'd0;
        issue.vblank = vblank_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                regfile_reg[i] <= 8'd0;
            end
            vblank_reg    <= 1'b0;
            latch_reg     <= LATCH_EMPTY;
            addr_high_reg <= 8'd0;
            vram_reg      <= 16'd0;
            step_row_reg  <= 1'b0;
            nt_sel_reg    <= 2'd0;
            dot_reg       <= 9'd0;
            line_reg      <= 9'd0;
            attr_pend_reg <= 1'b0;
        end else begin
            if (is_write) begin
                regfile_reg[s_reg_index] <= s_write_data;
            end
            vblank_reg    <= vblank_next;
            latch_reg     <= latch_next;
            addr_high_reg <= addr_high_next;
            vram_reg      <= vram_next;
            step_row_reg  <= step_row_next;
            nt_sel_reg    <= nt_sel_next;
            dot_reg       <= dot_next;
            line_reg      <= line_next;
            attr_pend_reg <= fetch_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (fetch_now) begin
            attr_addr_reg <= attr_addr_next;
        end
    end

endmodule

// ===== hdl/vurt_resq.sv =====
// ----------------------------------------------------------------------------
// vurt_resq
// Fetch capture stages and result queue toward the output channel.
// ----------------------------------------------------------------------------
module vurt_resq (
    input  logic             aclk,
    input  logic             aresetn,
    input  vurt_pkg::issue_t issue,
    input  logic [7:0]       rdata,
    output logic             room,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_read_data,
    output logic             m_vblank_flag,
    output logic [7:0]       m_tile_byte,
    output logic [7:0]       m_attr_byte
);
    import vurt_pkg::*;

    localparam int QAW = $clog2(QDEPTH);
    localparam int CW  = $clog2(QDEPTH + 1);

    issue_t         s1_reg;
    issue_t         s2_reg;
    logic [7:0]     tile_reg, tile_next;
    logic [7:0]     attr_reg, attr_next;
    result_t        q_reg [QDEPTH];
    logic [QAW-1:0] wptr_reg;
    logic [QAW-1:0] rptr_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW:0]    occupancy;
    result_t        push_entry;
    logic           push;
    logic           pop;
    result_t        head;

    always_comb begin
        push             = s2_reg.valid;
        pop              = m_valid && m_ready;
        tile_next        = (s1_reg.valid && s1_reg.fetch) ? rdata : tile_reg;
        attr_next        = (s2_reg.valid && s2_reg.fetch) ? rdata : attr_reg;
        push_entry.rd     = s2_reg.rd;
        push_entry.vblank = s2_reg.vblank;
        push_entry.tile   = tile_reg;
        push_entry.attr   = attr_next;
        count_next       = count_reg + CW'(push) - CW'(pop);
        occupancy        = (CW+1)'(count_reg) + (CW+1)'(s1_reg.valid) + (CW+1)'(s2_reg.valid);
        room             = occupancy < (CW+1)'(QDEPTH);
        head             = q_reg[rptr_reg];
    end

    assign m_valid       = (count_reg != '0);
    assign m_read_data   = head.rd;
    assign m_vblank_flag = head.vblank;
    assign m_tile_byte   = head.tile;
    assign m_attr_byte   = head.attr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            tile_reg     <= 8'd0;
            attr_reg     <= 8'd0;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            count_reg    <= '0;
        end else begin
            s1_reg       <= issue;
            s2_reg       <= s1_reg;
            tile_reg     <= tile_next;
            attr_reg     <= attr_next;
            count_reg    <= count_next;
            if (push) begin
                wptr_reg <= wptr_reg + QAW'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + QAW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/video_unit_register_and_timing_top.sv =====
// ----------------------------------------------------------------------------
// video_unit_register_and_timing_top
// A request passes capture stages s1 and s2 into the result queue.
// Throughput: one request per cycle while the queue has room; s_ready drops
// after a fetch tick for its attribute read on the single name memory port.
// Reset (aresetn low, synchronous) clears registers, counters and the result
// queue; name memory contents are kept and need no clearing.
// ----------------------------------------------------------------------------
module video_unit_register_and_timing_top #(
    parameter int NAME_BYTES = vurt_pkg::NAME_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [2:0] s_reg_index,
    input  logic [7:0] s_write_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_vblank_flag,
    output logic [7:0] m_tile_byte,
    output logic [7:0] m_attr_byte
);
    import vurt_pkg::*;

    mem_req_t   mreq;
    issue_t     iss;
    logic [7:0] rdata;
    logic       room;

    vurt_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_reg_index  (s_reg_index),
        .s_write_data (s_write_data),
        .room         (room),
        .issue        (iss),
        .mreq         (mreq)
    );

    vurt_vmem #(
        .NAME_BYTES (NAME_BYTES)
    ) u_vmem (
        .aclk  (aclk),
        .mreq  (mreq),
        .rdata (rdata)
    );

    vurt_resq u_resq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .issue         (iss),
        .rdata         (rdata),
        .room          (room),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_vblank_flag (m_vblank_flag),
        .m_tile_byte   (m_tile_byte),
        .m_attr_byte   (m_attr_byte)
    );

    a_port_exclusive : assert property (@(posedge aclk) disable iff (!aresetn)
        !(mreq.we && mreq.re))
        else $error("name memory read and write in the same cycle");

    a_fetch_reads : assert property (@(posedge aclk) disable iff (!aresetn)
        (iss.valid && iss.fetch) |-> mreq.re)
        else $error("fetch tick without a name memory read");

    a_fetch_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (iss.valid && iss.fetch) |=> (!s_ready && mreq.re))
        else $error("attribute read slot not reserved after fetch tick");

endmodule
